[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BED_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define BED_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/bed_pkg.sv]
// ----------------------------------------------------------------------------
// bed_pkg
// Shared sizes, codes and types of the button event detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bed_pkg;

   localparam int PIN_COUNT     = 4;
   localparam int VIRTUAL_COUNT = 6;
   localparam int QUEUE_DEPTH   = 16;

   localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CNT_W  = $clog2(VIRTUAL_COUNT + 1);
   localparam int SUM_W  = ((FILL_W > CNT_W) ? FILL_W : CNT_W) + 1;

   localparam int BTN_W      = 3;
   localparam int CODE_W     = 3;
   localparam int FILTER_W   = 4;
   localparam int HOLD_W     = 8;
   localparam int PINSEL_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // Item functions
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // Event codes
   localparam logic [CODE_W-1:0] EV_DOWN   = 3'd0;
   localparam logic [CODE_W-1:0] EV_UP     = 3'd1;
   localparam logic [CODE_W-1:0] EV_LSTART = 3'd2;
   localparam logic [CODE_W-1:0] EV_LHOLD  = 3'd3;
   localparam logic [CODE_W-1:0] EV_LUP    = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_MASK = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_PRESS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_C1_FIRST    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_C1_SECOND   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_C2_FIRST    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_C2_SECOND   = 3'd7;

   // Key set of one virtual button
   typedef struct packed {
      logic                 combo;  // needs the first key held
      logic [PIN_COUNT-1:0] own;    // keys that do not break
      logic [PIN_COUNT-1:0] first;  // key that must be held first
      logic [PIN_COUNT-1:0] trig;   // key that completes the press
   } keys_type;

   // Push request of one virtual button
   typedef struct packed {
      logic              req;
      logic [CODE_W-1:0] code;
   } push_type;

   // One queue word
   typedef struct packed {
      logic [BTN_W-1:0]  btn;
      logic [CODE_W-1:0] code;
   } event_type;

   function automatic logic [PIN_COUNT-1:0] pin_bit(input int unsigned p);
      logic [PIN_COUNT-1:0] one;
      one = PIN_COUNT'(1);
      return (p < PIN_COUNT) ? (one << p) : '0;
   endfunction

endpackage

[rtl/bed_if.sv]
// ----------------------------------------------------------------------------
// bed_if
// Valid/ready channels of the button event detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bed_req_if;
   import bed_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 func;
   logic [PIN_COUNT-1:0] raw_levels;
   modport source (output valid, output func, output raw_levels, input ready);
   modport sink (input valid, input func, input raw_levels, output ready);
endinterface

interface bed_rsp_if;
   import bed_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 event_valid;
   logic [BTN_W-1:0]     button_index;
   logic [CODE_W-1:0]    event_code;
   logic [PIN_COUNT-1:0] stable_keys;
   logic [FILL_W-1:0]    queue_count;
   logic                 events_dropped;
   modport source (output valid, output event_valid, output button_index,
                   output event_code, output stable_keys, output queue_count,
                   output events_dropped, input ready);
   modport sink (input valid, input event_valid, input button_index,
                 input event_code, input stable_keys, input queue_count,
                 input events_dropped, output ready);
endinterface

interface bed_csr_if;
   import bed_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/bed_debounce.sv]
// ----------------------------------------------------------------------------
// bed_debounce
// Per-pin level filter producing the stable pressed bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bed_debounce (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick_go,
   input  logic [bed_pkg::PIN_COUNT-1:0] raw_levels,
   input  logic [bed_pkg::PIN_COUNT-1:0] active_mask,
   input  logic [bed_pkg::FILTER_W-1:0]  filter_ticks,
   output logic [bed_pkg::PIN_COUNT-1:0] stable_cur,
   output logic [bed_pkg::PIN_COUNT-1:0] stable_tick
);
   import bed_pkg::*;

   logic [PIN_COUNT-1:0] stable_ff, stable_in;
   logic [FILTER_W-1:0]  filt_ff [PIN_COUNT];
   logic [FILTER_W-1:0]  filt_in [PIN_COUNT];

   always_comb begin
      logic [FILTER_W-1:0] inc;
      stable_in = stable_ff;
      for (int p = 0; p < PIN_COUNT; p++) begin
         inc = filt_ff[p] + FILTER_W'(1);
         filt_in[p] = '0;
         // pressed when the raw level matches the active level
         if ((raw_levels[p] ~^ active_mask[p]) != stable_ff[p]) begin
            if (inc >= filter_ticks) begin
               stable_in[p] = ~stable_ff[p];
            end else begin
               filt_in[p] = inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= '0;
         for (int p = 0; p < PIN_COUNT; p++) filt_ff[p] <= '0;
      end else if (tick_go) begin
         stable_ff <= stable_in;
         for (int p = 0; p < PIN_COUNT; p++) filt_ff[p] <= filt_in[p];
      end
   end

   assign stable_cur  = stable_ff;
   assign stable_tick = stable_in;

endmodule

[rtl/bed_button.sv]
// ----------------------------------------------------------------------------
// bed_button
// Press machine of one virtual button: idle, down, long and break.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bed_button (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick_go,
   input  logic [bed_pkg::PIN_COUNT-1:0] stable,
   input  bed_pkg::keys_type             keys,
   input  logic [bed_pkg::HOLD_W-1:0]    long_press_ticks,
   input  logic [bed_pkg::HOLD_W-1:0]    hold_ticks,
   output bed_pkg::push_type             push
);
   import bed_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DOWN = 2'd1;
   localparam logic [1:0] ST_LONG = 2'd2;
   localparam logic [1:0] ST_BRK  = 2'd3;

   localparam logic [1:0] ACT_UP   = 2'd0;
   localparam logic [1:0] ACT_DOWN = 2'd1;
   localparam logic [1:0] ACT_BRK  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [HOLD_W-1:0] cnt_ff, cnt_in;
   logic [1:0]        act;

   // judge the keys
   always_comb begin
      if ((stable & ~keys.own) != '0) begin
         act = ACT_BRK;
      end else if (keys.combo && ((stable & keys.first) == '0)) begin
         act = ACT_BRK;
      end else if ((stable & keys.trig) != '0) begin
         act = ACT_DOWN;
      end else begin
         act = ACT_UP;
      end
   end

   always_comb begin
      logic [HOLD_W-1:0] inc;
      logic [HOLD_W-1:0] lim;
      inc       = cnt_ff + HOLD_W'(1);
      lim       = (state_ff == ST_DOWN) ? long_press_ticks : hold_ticks;
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      push.req  = 1'b0;
      push.code = EV_DOWN;
      case (state_ff)
         ST_IDLE: begin
            if (act == ACT_DOWN) begin
               push.req = 1'b1;
               cnt_in   = '0;
               state_in = ST_DOWN;
            end
         end
         ST_DOWN, ST_LONG: begin
            if (act == ACT_BRK) begin
               state_in = ST_BRK;
            end else if (act == ACT_DOWN) begin
               cnt_in = inc;
               if (inc >= lim) begin
                  push.req  = 1'b1;
                  push.code = (state_ff == ST_DOWN) ? EV_LSTART : EV_LHOLD;
                  cnt_in    = '0;
                  state_in  = ST_LONG;
               end
            end else begin
               push.req  = 1'b1;
               push.code = (state_ff == ST_DOWN) ? EV_UP : EV_LUP;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            if (act == ACT_UP) state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else if (tick_go) begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[rtl/bed_queue.sv]
// ----------------------------------------------------------------------------
// bed_queue
// Event FIFO taking up to one word per button in a tick, one pop per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bed_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      tick_go,
   input  logic                      pop_go,
   input  bed_pkg::push_type         push [bed_pkg::VIRTUAL_COUNT],
   output logic                      pop_hit,
   output bed_pkg::event_type        pop_word,
   output logic [bed_pkg::FILL_W-1:0] fill_next,
   output logic                      dropped
);
   import bed_pkg::*;

   event_type        entry_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [FILL_W-1:0] fill_ff;

   logic [IDX_W-1:0] widx  [VIRTUAL_COUNT];
   logic [VIRTUAL_COUNT-1:0] take;
   logic [CNT_W-1:0] n_take;
   logic             lost;

   function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] r;
      r = (s >= SUM_W'(QUEUE_DEPTH)) ? (s - SUM_W'(QUEUE_DEPTH)) : s;
      return r[IDX_W-1:0];
   endfunction

   // prefix count of requests: the k-th request goes to wr + k if room remains
   always_comb begin
      logic [CNT_W-1:0] run;
      run    = '0;
      n_take = '0;
      lost   = 1'b0;
      for (int v = 0; v < VIRTUAL_COUNT; v++) begin
         take[v] = tick_go && push[v].req &&
                   ((SUM_W'(fill_ff) + SUM_W'(run)) < SUM_W'(QUEUE_DEPTH));
         widx[v] = wrap(SUM_W'(wr_ff) + SUM_W'(run));
         if (push[v].req) run = run + CNT_W'(1);
         if (take[v]) n_take = n_take + CNT_W'(1);
         if (tick_go && push[v].req && !take[v]) lost = 1'b1;
      end
   end

   assign pop_hit  = pop_go && (fill_ff != '0);
   assign pop_word = entry_ff[rd_ff];
   assign dropped  = lost;
   assign rd_in    = pop_hit ? wrap(SUM_W'(rd_ff) + SUM_W'(1)) : rd_ff;
   assign wr_in    = tick_go ? wrap(SUM_W'(wr_ff) + SUM_W'(n_take)) : wr_ff;

   always_comb begin
      logic [SUM_W-1:0] grown;
      grown = SUM_W'(fill_ff) + SUM_W'(n_take);
      if (tick_go) begin
         fill_next = grown[FILL_W-1:0];
      end else if (pop_hit) begin
         fill_next = fill_ff - FILL_W'(1);
      end else begin
         fill_next = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff   <= '0;
         wr_ff   <= '0;
         fill_ff <= '0;
      end else begin
         rd_ff   <= rd_in;
         wr_ff   <= wr_in;
         fill_ff <= fill_next;
      end
   end

   // storage words, written only where a request was taken
   always_ff @(posedge clock) begin
      for (int e = 0; e < QUEUE_DEPTH; e++) begin
         for (int v = 0; v < VIRTUAL_COUNT; v++) begin
            if (take[v] && (widx[v] == IDX_W'(e))) begin
               entry_ff[e].btn  <= BTN_W'(v);
               entry_ff[e].code <= push[v].code;
            end
         end
      end
   end

endmodule

[rtl/button_event_detector_top.sv]
// ----------------------------------------------------------------------------
// button_event_detector_top
// Debounced keys, six virtual button machines and an event queue.
// ----------------------------------------------------------------------------
//   channel    | dir | word
//   -----------+-----+---------------------------------------------------
//   req_port   | in  | func, raw_levels
//   rsp_port   | out | event_valid, button_index, event_code, stable_keys,
//              |     | queue_count, events_dropped
//   csr_port   | in  | index, data (always ready)
//
// One word per cycle sustained while results are taken; each word waits in the input
// register, its tick or pop work completes as it moves to the result register.
// Reset is synchronous: idle machines, empty queue, zero keys,
// configuration back to its defaults. Queue words carry no reset.
// A stalled result holds the result register and the input register; new
// words are still taken while the input register is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_event_detector_top (
   input logic clock,
   input logic reset,
   bed_req_if.sink   req_port,
   bed_rsp_if.source rsp_port,
   bed_csr_if.sink   csr_port
);
   import bed_pkg::*;

   // configuration
   logic [PIN_COUNT-1:0] mask_ff;
   logic [FILTER_W-1:0]  filter_ff;
   logic [HOLD_W-1:0]    long_ff, hold_ff;
   logic [PINSEL_W-1:0]  c1_first_ff, c1_second_ff, c2_first_ff, c2_second_ff;

   // input register
   logic                 in_vld_ff;
   logic                 in_func_ff;
   logic [PIN_COUNT-1:0] in_raw_ff;

   // result register
   logic                 out_vld_ff;
   logic                 out_evt_ff;
   logic [BTN_W-1:0]     out_btn_ff;
   logic [CODE_W-1:0]    out_code_ff;
   logic [PIN_COUNT-1:0] out_keys_ff;
   logic [FILL_W-1:0]    out_count_ff;
   logic                 out_drop_ff;

   logic advance, tick_go, pop_go;
   logic [PIN_COUNT-1:0] stable_cur, stable_tick;
   keys_type  keys [VIRTUAL_COUNT];
   push_type  push [VIRTUAL_COUNT];
   logic      pop_hit;
   event_type pop_word;
   logic [FILL_W-1:0] fill_next;
   logic      dropped;

   // advance the input word when the result register is free or being taken
   assign advance = in_vld_ff && (!out_vld_ff || rsp_port.ready);
   assign tick_go = advance && (in_func_ff == FUNC_TICK);
   assign pop_go  = advance && (in_func_ff == FUNC_POP);

   assign req_port.ready = !in_vld_ff || advance;
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_port.ready) begin
         in_vld_ff <= req_port.valid;
      end
   end

   // hold the payload until it advances
   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         in_func_ff <= req_port.func;
         in_raw_ff  <= req_port.raw_levels;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= PIN_COUNT'(8);
         filter_ff    <= FILTER_W'(2);
         long_ff      <= HOLD_W'(100);
         hold_ff      <= HOLD_W'(5);
         c1_first_ff  <= PINSEL_W'(3);
         c1_second_ff <= PINSEL_W'(0);
         c2_first_ff  <= PINSEL_W'(3);
         c2_second_ff <= PINSEL_W'(2);
      end else if (csr_port.valid && csr_port.ready) begin
         case (csr_port.index)
            REG_ACTIVE_MASK: mask_ff      <= PIN_COUNT'(csr_port.data);
            REG_FILTER:      filter_ff    <= FILTER_W'(csr_port.data);
            REG_LONG_PRESS:  long_ff      <= HOLD_W'(csr_port.data);
            REG_HOLD:        hold_ff      <= HOLD_W'(csr_port.data);
            REG_C1_FIRST:    c1_first_ff  <= PINSEL_W'(csr_port.data);
            REG_C1_SECOND:   c1_second_ff <= PINSEL_W'(csr_port.data);
            REG_C2_FIRST:    c2_first_ff  <= PINSEL_W'(csr_port.data);
            REG_C2_SECOND:   c2_second_ff <= PINSEL_W'(csr_port.data);
            default: ;
         endcase
      end
   end

   bed_debounce u_debounce (
      .clock        (clock),
      .reset        (reset),
      .tick_go      (tick_go),
      .raw_levels   (in_raw_ff),
      .active_mask  (mask_ff),
      .filter_ticks (filter_ff),
      .stable_cur   (stable_cur),
      .stable_tick  (stable_tick)
   );

   // Key sets: singles on their own pin, the last two are ordered combos.
   // A single with no pin of its own breaks on any key and never presses.
   for (genvar v = 0; v < VIRTUAL_COUNT; v++) begin : g_btn
      if (v < VIRTUAL_COUNT - 2) begin : g_single
         assign keys[v].combo = 1'b0;
         assign keys[v].own   = pin_bit(v);
         assign keys[v].first = '0;
         assign keys[v].trig  = pin_bit(v);
      end else if (v == VIRTUAL_COUNT - 2) begin : g_combo_one
         assign keys[v].combo = 1'b1;
         assign keys[v].own   = pin_bit(32'(c1_first_ff)) | pin_bit(32'(c1_second_ff));
         assign keys[v].first = pin_bit(32'(c1_first_ff));
         assign keys[v].trig  = pin_bit(32'(c1_second_ff));
      end else begin : g_combo_two
         assign keys[v].combo = 1'b1;
         assign keys[v].own   = pin_bit(32'(c2_first_ff)) | pin_bit(32'(c2_second_ff));
         assign keys[v].first = pin_bit(32'(c2_first_ff));
         assign keys[v].trig  = pin_bit(32'(c2_second_ff));
      end

      // machines judge the keys as they stand after this tick's filter
      bed_button u_button (
         .clock            (clock),
         .reset            (reset),
         .tick_go          (tick_go),
         .stable           (stable_tick),
         .keys             (keys[v]),
         .long_press_ticks (long_ff),
         .hold_ticks       (hold_ff),
         .push             (push[v])
      );
   end

   bed_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .tick_go   (tick_go),
      .pop_go    (pop_go),
      .push      (push),
      .pop_hit   (pop_hit),
      .pop_word  (pop_word),
      .fill_next (fill_next),
      .dropped   (dropped)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   // load the result word; tick results carry no event, pops drop nothing
   always_ff @(posedge clock) begin
      if (advance) begin
         out_evt_ff   <= pop_hit;
         out_btn_ff   <= pop_hit ? pop_word.btn : '0;
         out_code_ff  <= pop_hit ? pop_word.code : '0;
         out_keys_ff  <= tick_go ? stable_tick : stable_cur;
         out_count_ff <= fill_next;
         out_drop_ff  <= tick_go && dropped;
      end
   end

   assign rsp_port.valid          = out_vld_ff;
   assign rsp_port.event_valid    = out_evt_ff;
   assign rsp_port.button_index   = out_btn_ff;
   assign rsp_port.event_code     = out_code_ff;
   assign rsp_port.stable_keys    = out_keys_ff;
   assign rsp_port.queue_count    = out_count_ff;
   assign rsp_port.events_dropped = out_drop_ff;

endmodule

[rtl/bed_checker.sv]
// ----------------------------------------------------------------------------
// bed_checker
// Port-level checks on the button event detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bed_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_event_valid,
   input logic [bed_pkg::BTN_W-1:0]       rsp_button_index,
   input logic [bed_pkg::CODE_W-1:0]      rsp_event_code,
   input logic [bed_pkg::PIN_COUNT-1:0]   rsp_stable_keys,
   input logic [bed_pkg::FILL_W-1:0]      rsp_queue_count,
   input logic                            rsp_events_dropped
);
   import bed_pkg::*;

   logic [BTN_W+CODE_W+PIN_COUNT+FILL_W+1:0] rsp_word;
   logic                                      pop_ok;

   assign rsp_word = {rsp_event_valid, rsp_button_index, rsp_event_code,
                      rsp_stable_keys, rsp_queue_count, rsp_events_dropped};
   assign pop_ok   = !rsp_events_dropped && (rsp_button_index < BTN_W'(VIRTUAL_COUNT)) &&
                     (rsp_event_code <= EV_LUP);

   // a stalled result holds its word
   `BED_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // input only backs up behind a stalled result
   `BED_ASSERT_NOW(a_req_stall, !req_ready, rsp_valid && !rsp_ready)

   `BED_ASSERT_NOW(a_count_range, rsp_valid, rsp_queue_count <= FILL_W'(QUEUE_DEPTH))

   // a returned event never reports a drop and names a real button and code
   `BED_ASSERT_NOW(a_pop_word, rsp_valid && rsp_event_valid, pop_ok)

   `BED_ASSERT_NOW(a_no_event, rsp_valid && !rsp_event_valid, rsp_button_index == '0)

endmodule

bind button_event_detector_top bed_checker u_bed_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_port.ready),
   .rsp_valid          (rsp_port.valid),
   .rsp_ready          (rsp_port.ready),
   .rsp_event_valid    (rsp_port.event_valid),
   .rsp_button_index   (rsp_port.button_index),
   .rsp_event_code     (rsp_port.event_code),
   .rsp_stable_keys    (rsp_port.stable_keys),
   .rsp_queue_count    (rsp_port.queue_count),
   .rsp_events_dropped (rsp_port.events_dropped)
);

[tb/sv/button_event_detector_top_tb.sv]
// ----------------------------------------------------------------------------
// button_event_detector_top_tb
// Self-checking bench for the button event detector. A local model follows
// every accepted tick or pop word and predicts the result word that it
// causes. Directed key sequences run first, then register extremes, queue
// overflow and random-configuration phases of key presses, combos, bounce
// and noise, with random gaps on the request side and stalls on the
// result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_event_detector_top_tb;
   import bed_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 6;

   typedef enum logic [1:0] {M_IDLE, M_DOWN, M_LONG, M_BRK} mach_state_type;
   typedef enum logic [1:0] {PR_UP, PR_DOWN, PR_BREAK} press_type;

   // one predicted result word
   typedef struct packed {
      logic                 ev_valid;
      logic [BTN_W-1:0]     btn;
      logic [CODE_W-1:0]    code;
      logic [PIN_COUNT-1:0] keys;
      logic [FILL_W-1:0]    count;
      logic                 dropped;
   } key_report_type;

   logic clock;
   logic reset;

   bed_req_if req_bus ();
   bed_rsp_if rsp_bus ();
   bed_csr_if csr_bus ();

   button_event_detector_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // -------------------------------------------------------------------------
   // Model state: configuration, debounce, button machines, event queue
   // -------------------------------------------------------------------------
   logic [PIN_COUNT-1:0]  cfg_active_mask;
   logic [FILTER_W-1:0]   cfg_filter;
   logic [HOLD_W-1:0]     cfg_long;
   logic [HOLD_W-1:0]     cfg_hold;
   logic [PINSEL_W-1:0]   cfg_c1_first;
   logic [PINSEL_W-1:0]   cfg_c1_second;
   logic [PINSEL_W-1:0]   cfg_c2_first;
   logic [PINSEL_W-1:0]   cfg_c2_second;

   logic [PIN_COUNT-1:0]  key_stable;
   logic [FILTER_W-1:0]   flt_cnt  [PIN_COUNT];
   mach_state_type        mach     [VIRTUAL_COUNT];
   logic [HOLD_W-1:0]     held_cnt [VIRTUAL_COUNT];
   event_type             pending_events [$];
   logic                  overflow_seen;

   key_report_type        expected_reports [$];
   key_report_type        want_rpt;
   key_report_type        seen_rpt;

   int                    fail_count;
   int                    items_sent;
   int                    burst_left;

   task automatic model_reset();
      // power-on register values of the block
      cfg_active_mask = 4'd8;
      cfg_filter      = 4'd2;
      cfg_long        = 8'd100;
      cfg_hold        = 8'd5;
      cfg_c1_first    = 2'd3;
      cfg_c1_second   = 2'd0;
      cfg_c2_first    = 2'd3;
      cfg_c2_second   = 2'd2;
      key_stable      = '0;
      foreach (flt_cnt[p]) flt_cnt[p] = '0;
      foreach (mach[v]) begin
         mach[v]     = M_IDLE;
         held_cnt[v] = '0;
      end
      pending_events.delete();
      overflow_seen = 1'b0;
   endtask

   function automatic logic [PIN_COUNT-1:0] key_bit(input int unsigned p);
      return (p < PIN_COUNT) ? (PIN_COUNT'(1) << p) : '0;
   endfunction

   // raw pin levels that read as the given pressed set
   function automatic logic [PIN_COUNT-1:0] levels_for(input logic [PIN_COUNT-1:0] pressed);
      return ~(pressed ^ cfg_active_mask);
   endfunction

   function automatic void filter_keys(input logic [PIN_COUNT-1:0] levels);
      logic pressed;
      for (int p = 0; p < PIN_COUNT; p++) begin
         pressed = (levels[p] == cfg_active_mask[p]);
         if (pressed != key_stable[p]) begin
            flt_cnt[p] = flt_cnt[p] + 1'b1;
            // a zero filter setting toggles on the first differing tick
            if (flt_cnt[p] >= cfg_filter) begin
               key_stable[p] = ~key_stable[p];
               flt_cnt[p]    = '0;
            end
         end else begin
            flt_cnt[p] = '0;
         end
      end
   endfunction

   function automatic press_type judge_button(input int v);
      logic [PIN_COUNT-1:0] own;
      logic [PIN_COUNT-1:0] first_k;
      logic [PIN_COUNT-1:0] trig_k;
      if (v < VIRTUAL_COUNT - 2) begin
         // a single with no pin of its own breaks on any key
         own = key_bit(v);
         if ((key_stable & ~own) != '0) return PR_BREAK;
         return ((key_stable & own) != '0) ? PR_DOWN : PR_UP;
      end
      first_k = key_bit((v == VIRTUAL_COUNT - 2) ? cfg_c1_first  : cfg_c2_first);
      trig_k  = key_bit((v == VIRTUAL_COUNT - 2) ? cfg_c1_second : cfg_c2_second);
      own     = first_k | trig_k;
      if ((key_stable & ~own) != '0 || (key_stable & first_k) == '0) return PR_BREAK;
      return ((key_stable & trig_k) != '0) ? PR_DOWN : PR_UP;
   endfunction

   function automatic void queue_event(input int v, input logic [CODE_W-1:0] code);
      event_type ev;
      if (pending_events.size() >= QUEUE_DEPTH) begin
         overflow_seen = 1'b1;
      end else begin
         ev.btn  = BTN_W'(v);
         ev.code = code;
         pending_events.push_back(ev);
      end
   endfunction

   function automatic void step_button(input int v);
      press_type          act;
      logic [HOLD_W-1:0]  limit;
      act = judge_button(v);
      case (mach[v])
         M_IDLE: begin
            if (act == PR_DOWN) begin
               queue_event(v, EV_DOWN);
               held_cnt[v] = '0;
               mach[v]     = M_DOWN;
            end
         end
         M_DOWN, M_LONG: begin
            if (act == PR_BREAK) begin
               mach[v] = M_BRK;
            end else if (act == PR_DOWN) begin
               limit       = (mach[v] == M_DOWN) ? cfg_long : cfg_hold;
               held_cnt[v] = held_cnt[v] + 1'b1;
               if (held_cnt[v] >= limit) begin
                  queue_event(v, (mach[v] == M_DOWN) ? EV_LSTART : EV_LHOLD);
                  held_cnt[v] = '0;
                  mach[v]     = M_LONG;
               end
            end else begin
               queue_event(v, (mach[v] == M_DOWN) ? EV_UP : EV_LUP);
               mach[v] = M_IDLE;
            end
         end
         default: begin
            if (act == PR_UP) mach[v] = M_IDLE;
         end
      endcase
   endfunction

   function automatic key_report_type predict_report(input logic func_bit,
                                                     input logic [PIN_COUNT-1:0] levels);
      key_report_type rpt;
      event_type      head;
      rpt           = '0;
      overflow_seen = 1'b0;
      if (func_bit == FUNC_TICK) begin
         filter_keys(levels);
         for (int v = 0; v < VIRTUAL_COUNT; v++) step_button(v);
      end else if (pending_events.size() != 0) begin
         head         = pending_events.pop_front();
         rpt.ev_valid = 1'b1;
         rpt.btn      = head.btn;
         rpt.code     = head.code;
      end
      rpt.keys    = key_stable;
      rpt.count   = FILL_W'(pending_events.size());
      rpt.dropped = overflow_seen;
      return rpt;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_ACTIVE_MASK: cfg_active_mask = data[PIN_COUNT-1:0];
         REG_FILTER:      cfg_filter      = data[FILTER_W-1:0];
         REG_LONG_PRESS:  cfg_long        = data[HOLD_W-1:0];
         REG_HOLD:        cfg_hold        = data[HOLD_W-1:0];
         REG_C1_FIRST:    cfg_c1_first    = data[PINSEL_W-1:0];
         REG_C1_SECOND:   cfg_c1_second   = data[PINSEL_W-1:0];
         REG_C2_FIRST:    cfg_c2_first    = data[PINSEL_W-1:0];
         REG_C2_SECOND:   cfg_c2_second   = data[PINSEL_W-1:0];
         default:         ;
      endcase
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] seen);
      if (seen !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, seen);
         fail_count++;
      end
   endfunction

   // -------------------------------------------------------------------------
   // Clock, timeout
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // end the run if it never drains
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Monitor: track register writes and accepted words at the rising edge,
   // predict at request acceptance, check at result acceptance
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) apply_register(csr_bus.index, csr_bus.data);
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_rpt.ev_valid = rsp_bus.event_valid;
            seen_rpt.btn      = rsp_bus.button_index;
            seen_rpt.code     = rsp_bus.event_code;
            seen_rpt.keys     = rsp_bus.stable_keys;
            seen_rpt.count    = rsp_bus.queue_count;
            seen_rpt.dropped  = rsp_bus.events_dropped;
            if (expected_reports.size() == 0) begin
               $display("%0t: result word with nothing expected, expected none actual %h",
                        $time, seen_rpt);
               fail_count++;
            end else begin
               want_rpt = expected_reports.pop_front();
               compare_field("event_valid",    want_rpt.ev_valid, seen_rpt.ev_valid);
               compare_field("button_index",   want_rpt.btn,      seen_rpt.btn);
               compare_field("event_code",     want_rpt.code,     seen_rpt.code);
               compare_field("stable_keys",    want_rpt.keys,     seen_rpt.keys);
               compare_field("queue_count",    want_rpt.count,    seen_rpt.count);
               compare_field("events_dropped", want_rpt.dropped,  seen_rpt.dropped);
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_reports.push_back(predict_report(req_bus.func, req_bus.raw_levels));
      end
   end

   // -------------------------------------------------------------------------
   // Result side: stall on a pattern drawn at random and redrawn when its run ends
   // (always ready, short periodic drop, mostly stalled, coin toss)
   // -------------------------------------------------------------------------
   initial begin
      int mode;
      int period;
      int phase;
      int left;
      rsp_bus.ready = 1'b0;
      mode   = 0;
      period = 2;
      phase  = 0;
      left   = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode   = $urandom_range(0, 3);
            period = $urandom_range(2, 9);
            left   = $urandom_range(16, 96);
         end
         left--;
         phase = (phase + 1) % period;
         case (mode)
            0:       rsp_bus.ready = 1'b1;
            1:       rsp_bus.ready = (phase != 0);
            2:       rsp_bus.ready = (phase == 0);
            default: rsp_bus.ready = 1'($urandom_range(0, 1));
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Request side helpers; every task starts and ends at a falling edge
   // -------------------------------------------------------------------------

   // send one word; bursts of random length with random gaps in between
   task automatic send_word(input logic func_bit, input logic [PIN_COUNT-1:0] levels);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         // scramble the idle payload so only valid qualifies it
         req_bus.func       = 1'($urandom);
         req_bus.raw_levels = PIN_COUNT'($urandom);
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_bus.valid      = 1'b1;
      req_bus.func       = func_bit;
      req_bus.raw_levels = levels;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
      req_bus.valid = 1'b0;
      items_sent++;
   endtask

   task automatic tick_keys(input logic [PIN_COUNT-1:0] pressed);
      send_word(FUNC_TICK, levels_for(pressed));
   endtask

   // hold a pressed set for some ticks, with stray pops and one-tick bounce
   task automatic hold_keys(input logic [PIN_COUNT-1:0] pressed, input int ticks,
                            input int pop_pct);
      logic [PIN_COUNT-1:0] lv;
      for (int i = 0; i < ticks; i++) begin
         if ($urandom_range(1, 100) <= pop_pct) send_word(FUNC_POP, PIN_COUNT'($urandom));
         lv = levels_for(pressed);
         if ($urandom_range(0, 9) == 0) lv ^= key_bit($urandom_range(0, PIN_COUNT - 1));
         send_word(FUNC_TICK, lv);
      end
   endtask

   // hold until every predicted word has come back, then let the pipe settle
   task automatic wait_idle();
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // write every register while idle; junk in the unused upper data bits
   task automatic write_all_regs(input logic [3:0] mask, input logic [3:0] flt,
                                 input logic [7:0] long_t, input logic [7:0] hold_t,
                                 input logic [1:0] c1f, input logic [1:0] c1s,
                                 input logic [1:0] c2f, input logic [1:0] c2s);
      wait_idle();
      write_reg(REG_ACTIVE_MASK, {4'($urandom), mask});
      write_reg(REG_FILTER,      {4'($urandom), flt});
      write_reg(REG_LONG_PRESS,  long_t);
      write_reg(REG_HOLD,        hold_t);
      write_reg(REG_C1_FIRST,    {6'($urandom), c1f});
      write_reg(REG_C1_SECOND,   {6'($urandom), c1s});
      write_reg(REG_C2_FIRST,    {6'($urandom), c2f});
      write_reg(REG_C2_SECOND,   {6'($urandom), c2s});
   endtask

   // pop until the queue is empty, plus one pop on the empty queue
   task automatic drain_events();
      while (pending_events.size() != 0) send_word(FUNC_POP, PIN_COUNT'($urandom));
      send_word(FUNC_POP, PIN_COUNT'($urandom));
   endtask

   // one press gesture: single, ordered combo, reversed combo, random set or noise
   task automatic press_sequence(input int pop_pct);
      int                   kind;
      int                   max_hold;
      int                   settle;
      logic [PIN_COUNT-1:0] first_k;
      logic [PIN_COUNT-1:0] trig_k;
      logic [PIN_COUNT-1:0] keys;
      kind     = $urandom_range(0, 9);
      max_hold = int'(cfg_long) + 2 * int'(cfg_hold) + 3;
      if (max_hold > 30) max_hold = 30;
      settle   = int'(cfg_filter);
      if ($urandom_range(0, 1)) begin
         first_k = key_bit(cfg_c1_first);
         trig_k  = key_bit(cfg_c1_second);
      end else begin
         first_k = key_bit(cfg_c2_first);
         trig_k  = key_bit(cfg_c2_second);
      end
      if (kind <= 3) begin
         keys = key_bit($urandom_range(0, PIN_COUNT - 1));
         hold_keys(keys, settle + $urandom_range(0, max_hold), pop_pct);
      end else if (kind <= 6) begin
         hold_keys(first_k, settle + $urandom_range(1, 3), pop_pct);
         hold_keys(first_k | trig_k, settle + $urandom_range(0, max_hold), pop_pct);
         if ($urandom_range(0, 1)) hold_keys(first_k, settle + $urandom_range(0, 3), pop_pct);
      end else if (kind == 7) begin
         keys = PIN_COUNT'($urandom);
         hold_keys(keys, settle + $urandom_range(0, max_hold), pop_pct);
      end else if (kind == 8) begin
         repeat ($urandom_range(1, 6)) send_word(FUNC_TICK, PIN_COUNT'($urandom));
      end else begin
         // wrong order: completing key first
         hold_keys(trig_k, settle + $urandom_range(1, 3), pop_pct);
         hold_keys(first_k | trig_k, settle + $urandom_range(0, max_hold), pop_pct);
      end
      hold_keys('0, settle + $urandom_range(1, 3), pop_pct);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // power-on registers: pop the empty queue, press pin 3 through the filter
   task automatic test_power_on_defaults();
      send_word(FUNC_POP, '0);
      tick_keys(4'b1000);
      tick_keys(4'b1000);
      send_word(FUNC_POP, '1);
   endtask

   // zero filter, long and hold; singles, long press chain, combos, equal-pin combo
   task automatic test_single_and_combo();
      write_all_regs(4'hF, 4'd0, 8'd0, 8'd0, 2'd3, 2'd0, 2'd2, 2'd2);
      tick_keys(4'b0001);    // down
      tick_keys(4'b0001);    // long start on the next held tick
      tick_keys(4'b0001);    // long hold
      tick_keys(4'b0000);    // long up
      tick_keys(4'b1000);    // single three down
      tick_keys(4'b1001);    // combo one completes, single three breaks
      tick_keys(4'b1000);    // combo one released
      tick_keys(4'b0000);
      tick_keys(4'b0100);    // single two and the equal-pin combo together
      tick_keys(4'b0000);
      tick_keys(4'b1111);    // every machine sees a foreign key
      tick_keys(4'b0000);
      drain_events();
   endtask

   // mask, filter and timing registers at their far ends: active low, widest filter, longest presses
   task automatic test_register_extremes();
      write_all_regs(4'h0, 4'd15, 8'd255, 8'd255, 2'd0, 2'd3, 2'd1, 2'd1);
      hold_keys(4'b0001, 15 + 258, 3);
      hold_keys('0, 17, 3);
      press_sequence(20);
      drain_events();
   endtask

   // shortest timings and rare pops so the queue fills and drops events
   task automatic test_queue_overflow();
      int start;
      write_all_regs(4'hF, 4'd1, 8'd1, 8'd1, 2'd3, 2'd3, 2'd0, 2'd3);
      start = items_sent;
      while (items_sent - start < 40) press_sequence(4);
      drain_events();
   endtask

   // random registers per phase; one phase pauses mid-way until all results came
   task automatic test_random_configs();
      int                  start;
      int                  pop_pct;
      logic [FILTER_W-1:0] flt;
      logic                paused;
      paused = 1'b0;
      for (int ph = 0; ph < 5; ph++) begin
         flt = ($urandom_range(0, 7) == 0) ? FILTER_W'($urandom_range(5, 15))
                                           : FILTER_W'($urandom_range(0, 4));
         write_all_regs(PIN_COUNT'($urandom), flt, 8'($urandom_range(0, 10)),
                        8'($urandom_range(0, 5)), 2'($urandom), 2'($urandom),
                        2'($urandom), 2'($urandom));
         pop_pct = $urandom_range(10, 50);
         start   = items_sent;
         while (items_sent - start < 25) begin
            press_sequence(pop_pct);
            if (ph == 2 && !paused && items_sent - start >= 10) begin
               wait_idle();
               paused = 1'b1;
            end
         end
      end
      drain_events();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.func       = FUNC_TICK;
      req_bus.raw_levels = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = REG_ACTIVE_MASK;
      csr_bus.data       = '0;
      fail_count         = 0;
      items_sent         = 0;
      burst_left         = 0;
      model_reset();
      expected_reports.delete();

      // hold reset, then release it on a falling edge
      repeat (10) @(negedge clock);
      reset = 1'b0;
      repeat (2) @(negedge clock);

      test_power_on_defaults();
      test_single_and_combo();
      test_register_extremes();
      test_queue_overflow();
      test_random_configs();

      // drop the request side and let the last results drain
      wait_idle();
      if (expected_reports.size() != 0) begin
         $display("%0t: %0d result words never arrived", $time, expected_reports.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/bed_pkg.sv
rtl/bed_if.sv
rtl/bed_debounce.sv
rtl/bed_button.sv
rtl/bed_queue.sv
rtl/button_event_detector_top.sv
rtl/bed_checker.sv
tb/sv/button_event_detector_top_tb.sv
